>>> hw/rtl/dtle_pkg.sv
// ----------------------------------------------------------------------------
// dtle_pkg
// Types, register indexes and constants of the dual-tier latency estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package dtle_pkg;

    localparam int WordW  = 64;
    localparam int OperW  = 80;
    localparam int CntW   = 7;
    localparam int RegW   = 16;
    localparam int IdxW   = 8;
    localparam int ShiftW = 3;
    localparam int NsW    = 74;

    localparam logic [CntW-1:0] WordSteps = CntW'(64);
    localparam logic [CntW-1:0] NsSteps   = CntW'(74);

    localparam logic [9:0] NsPerUs = 10'd1000;

    localparam logic [ShiftW-1:0] ShiftReset   = 3'd1;
    localparam logic [RegW-1:0]   LocalMinReset  = 16'd15;
    localparam logic [RegW-1:0]   RemoteMinReset = 16'd30;
    localparam logic [RegW-1:0]   ClockMhzReset  = 16'd2200;

    localparam logic [IdxW-1:0] RegSmoothingShift  = 8'd0;
    localparam logic [IdxW-1:0] RegLocalMinLatency = 8'd1;
    localparam logic [IdxW-1:0] RegRemoteMinLatency = 8'd2;
    localparam logic [IdxW-1:0] RegClockMhz        = 8'd3;

    typedef enum logic {
        OP_DIV,
        OP_MUL
    } arith_op_t;

    typedef struct packed {
        logic            start;
        arith_op_t       op;
        logic [CntW-1:0] nbits;
    } arith_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SMOOTH,
        ST_CHECK,
        ST_QUO,
        ST_TNS,
        ST_MUL,
        ST_LAT,
        ST_NEXT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [WordW-1:0] local_occupancy_count;
        logic [WordW-1:0] local_insert_count;
        logic [WordW-1:0] local_clocktick_count;
        logic [WordW-1:0] local_timestamp;
        logic [WordW-1:0] remote_occupancy_count;
        logic [WordW-1:0] remote_insert_count;
        logic [WordW-1:0] remote_clocktick_count;
        logic [WordW-1:0] remote_timestamp;
    } sample_t;

    typedef struct packed {
        logic [WordW-1:0] local_latency;
        logic [WordW-1:0] remote_latency;
        logic             local_slower;
        logic [WordW-1:0] local_interval_ticks;
        logic [WordW-1:0] remote_interval_ticks;
        logic [WordW-1:0] local_clocktick_delta;
        logic [WordW-1:0] remote_clocktick_delta;
    } result_t;

    typedef struct packed {
        logic [IdxW-1:0] index;
        logic [RegW-1:0] value;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/dtle_stream_if.sv
// ----------------------------------------------------------------------------
// dtle_stream_if
// Valid/ready channel carrying one payload beat of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtle_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dtle_arith.sv
// ----------------------------------------------------------------------------
// dtle_arith
// Shared bit-serial divide and saturating multiply unit, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dtle_arith (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dtle_pkg::arith_cmd_t         cmd,
    input  logic [dtle_pkg::OperW-1:0]   a,
    input  logic [dtle_pkg::WordW-1:0]   b,
    output dtle_pkg::arith_sts_t         sts,
    output logic [dtle_pkg::OperW-1:0]   res
);
    import dtle_pkg::*;

    logic [OperW-1:0] opnd_reg;
    logic [OperW-1:0] opnd_next;
    logic [WordW-1:0] rem_reg;
    logic [WordW-1:0] rem_next;
    logic [WordW-1:0] divisor_reg;
    logic             sat_reg;
    logic             sat_next;
    logic [CntW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    arith_op_t        op_reg;

    logic             msb;
    logic [WordW:0]   lhs;
    logic [WordW:0]   addend;
    logic [WordW+1:0] sum;
    logic             is_div;

    assign is_div = (op_reg == OP_DIV);
    assign msb    = opnd_reg[OperW-1];

    always_comb
    begin
        if (is_div)
        begin
            lhs    = {rem_reg, msb};
            addend = ~{1'b0, divisor_reg};
        end
        else
        begin
            lhs    = {1'b0, rem_reg[WordW-2:0], 1'b0};
            addend = msb ? {1'b0, divisor_reg} : '0;
        end
        sum = {1'b0, lhs} + {1'b0, addend} + (WordW+2)'(is_div);

        if (is_div)
        begin
            rem_next  = sum[WordW+1] ? sum[WordW-1:0] : lhs[WordW-1:0];
            opnd_next = {opnd_reg[OperW-2:0], sum[WordW+1]};
            sat_next  = sat_reg;
        end
        else
        begin
            rem_next  = sum[WordW-1:0];
            opnd_next = {opnd_reg[OperW-2:0], 1'b0};
            sat_next  = sat_reg | rem_reg[WordW-1] | sum[WordW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= cmd.nbits;
            op_reg   <= cmd.op;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            opnd_reg    <= a;
            rem_reg     <= '0;
            divisor_reg <= b;
            sat_reg     <= 1'b0;
        end
        else if (busy_reg)
        begin
            opnd_reg <= opnd_next;
            rem_reg  <= rem_next;
            sat_reg  <= sat_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign res = is_div ? opnd_reg
                        : {(OperW-WordW)'(0), (sat_reg ? {WordW{1'b1}} : rem_reg)};

endmodule

`default_nettype wire

>>> hw/rtl/dual_tier_latency_estimator.sv
// ----------------------------------------------------------------------------
// dual_tier_latency_estimator
// Little's-law latency estimate for a local and a remote memory path.
// ----------------------------------------------------------------------------
// One sample beat carries raw occupancy, insert, clocktick and timestamp
// counters for both paths. The first beat after reset only primes the stored
// readings and gives no result; every later beat gives one result beat. The
// block takes one sample at a time, and while it holds a sample, the single
// bit-serial divide/multiply unit runs four operations per path (64, 74, 64
// and 64 steps) after four smoothing steps. A path with zero smoothed
// inserts or a zero clocktick delta skips its operations and reports its
// minimum. A finished result waits in an output register while the next
// sample is taken. Configuration writes are accepted in any cycle and must
// only be issued while the block is idle.
`default_nettype none

module dual_tier_latency_estimator (
    input  logic        clk,
    input  logic        rst_n,
    dtle_stream_if.sink   sample,
    dtle_stream_if.source result,
    dtle_stream_if.sink   cfg
);
    import dtle_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [ShiftW-1:0] shift_reg;
    logic [RegW-1:0]   lmin_reg;
    logic [RegW-1:0]   rmin_reg;
    logic [RegW-1:0]   mhz_reg;

    logic [WordW-1:0] prev_reg   [8];
    logic [WordW-1:0] delta_reg  [8];
    logic [WordW-1:0] smooth_reg [4];
    logic [WordW-1:0] in_word    [8];
    logic [WordW-1:0] lat_reg    [2];
    logic [WordW-1:0] q_reg;
    logic             primed_reg;
    logic             path_reg;
    logic [1:0]       idx_reg;

    logic    out_valid_reg;
    result_t out_data_reg;

    logic accept;
    logic out_load;

    logic [WordW-1:0]   sm_old;
    logic [WordW-1:0]   d_sel;
    logic [WordW+7:0]   sm_wide;
    logic [WordW-1:0]   sm_new;

    logic [WordW-1:0] socc;
    logic [WordW-1:0] sins;
    logic [WordW-1:0] dtsc;
    logic [WordW-1:0] dclk;
    logic [WordW-1:0] minlat;
    logic [RegW-1:0]  freq;
    logic [NsW-1:0]   ns_x;
    logic [WordW-1:0] t_sat;
    logic             fallback;

    arith_cmd_t       cmd;
    arith_sts_t       sts;
    logic [OperW-1:0] arith_a;
    logic [WordW-1:0] arith_b;
    logic [OperW-1:0] arith_res;

    dtle_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .a     (arith_a),
        .b     (arith_b),
        .sts   (sts),
        .res   (arith_res)
    );

    assign in_word[0] = sample.data.local_occupancy_count;
    assign in_word[1] = sample.data.local_insert_count;
    assign in_word[2] = sample.data.local_clocktick_count;
    assign in_word[3] = sample.data.local_timestamp;
    assign in_word[4] = sample.data.remote_occupancy_count;
    assign in_word[5] = sample.data.remote_insert_count;
    assign in_word[6] = sample.data.remote_clocktick_count;
    assign in_word[7] = sample.data.remote_timestamp;

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;
    assign out_load     = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);

    // moving average of one smoothed value per cycle
    always_comb
    begin
        sm_old = smooth_reg[idx_reg];
        case (idx_reg)
            2'd0:    d_sel = delta_reg[0];
            2'd1:    d_sel = delta_reg[1];
            2'd2:    d_sel = delta_reg[4];
            default: d_sel = delta_reg[5];
        endcase
        sm_wide = ({8'b0, sm_old} << shift_reg) - {8'b0, sm_old} + {8'b0, d_sel};
        sm_new  = WordW'(sm_wide >> shift_reg);
    end

    assign socc     = path_reg ? smooth_reg[2] : smooth_reg[0];
    assign sins     = path_reg ? smooth_reg[3] : smooth_reg[1];
    assign dtsc     = path_reg ? delta_reg[7]  : delta_reg[3];
    assign dclk     = path_reg ? delta_reg[6]  : delta_reg[2];
    assign minlat   = {(WordW-RegW)'(0), (path_reg ? rmin_reg : lmin_reg)};
    assign freq     = (mhz_reg == '0) ? RegW'(1) : mhz_reg;
    assign ns_x     = {(NsW-WordW)'(0), dtsc} * {(NsW-10)'(0), NsPerUs};
    assign t_sat    = (arith_res[OperW-1:WordW] != '0) ? {WordW{1'b1}}
                                                       : arith_res[WordW-1:0];
    assign fallback = (sins == '0) || (dclk == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.start  = 1'b0;
        cmd.op     = OP_DIV;
        cmd.nbits  = WordSteps;
        arith_a    = '0;
        arith_b    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && primed_reg)
                    state_next = ST_SMOOTH;
            end
            ST_SMOOTH:
            begin
                if (idx_reg == 2'd3)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (fallback)
                    state_next = ST_NEXT;
                else
                begin
                    cmd.start  = 1'b1;
                    arith_a    = {socc, (OperW-WordW)'(0)};
                    arith_b    = sins;
                    state_next = ST_QUO;
                end
            end
            ST_QUO:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.nbits  = NsSteps;
                    arith_a    = {ns_x, (OperW-NsW)'(0)};
                    arith_b    = {(WordW-RegW)'(0), freq};
                    state_next = ST_TNS;
                end
            end
            ST_TNS:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_MUL;
                    arith_a    = {q_reg, (OperW-WordW)'(0)};
                    arith_b    = t_sat;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (sts.done)
                begin
                    cmd.start  = 1'b1;
                    arith_a    = {arith_res[WordW-1:0], (OperW-WordW)'(0)};
                    arith_b    = dclk;
                    state_next = ST_LAT;
                end
            end
            ST_LAT:
            begin
                if (sts.done)
                    state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                state_next = path_reg ? ST_FINISH : ST_CHECK;
            end
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= ShiftReset;
            lmin_reg  <= LocalMinReset;
            rmin_reg  <= RemoteMinReset;
            mhz_reg   <= ClockMhzReset;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                RegSmoothingShift:   shift_reg <= cfg.data.value[ShiftW-1:0];
                RegLocalMinLatency:  lmin_reg  <= cfg.data.value;
                RegRemoteMinLatency: rmin_reg  <= cfg.data.value;
                RegClockMhz:         mhz_reg   <= cfg.data.value;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            path_reg   <= 1'b0;
            idx_reg    <= '0;
            for (int i = 0; i < 8; i++)
                prev_reg[i] <= '0;
            for (int i = 0; i < 4; i++)
                smooth_reg[i] <= '0;
        end
        else
        begin
            if (accept)
            begin
                primed_reg <= 1'b1;
                path_reg   <= 1'b0;
                idx_reg    <= '0;
                for (int i = 0; i < 8; i++)
                    prev_reg[i] <= in_word[i];
            end
            if (state_reg == ST_SMOOTH)
            begin
                smooth_reg[idx_reg] <= sm_new;
                idx_reg             <= idx_reg + 2'd1;
            end
            if (state_reg == ST_NEXT)
                path_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 8; i++)
                delta_reg[i] <= in_word[i] - prev_reg[i];
        end
        if (state_reg == ST_CHECK && fallback)
            lat_reg[path_reg] <= minlat;
        if (state_reg == ST_QUO && sts.done)
            q_reg <= arith_res[WordW-1:0];
        if (state_reg == ST_LAT && sts.done)
            lat_reg[path_reg] <= (arith_res[WordW-1:0] > minlat) ? arith_res[WordW-1:0]
                                                                 : minlat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.local_latency          <= lat_reg[0];
            out_data_reg.remote_latency         <= lat_reg[1];
            out_data_reg.local_slower           <= (lat_reg[0] > lat_reg[1]);
            out_data_reg.local_interval_ticks   <= delta_reg[3];
            out_data_reg.remote_interval_ticks  <= delta_reg[7];
            out_data_reg.local_clocktick_delta  <= delta_reg[2];
            out_data_reg.remote_clocktick_delta <= delta_reg[6];
        end
    end

`ifndef SYNTHESIS
    a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        sample.ready |-> !sts.busy)
        else $error("sample taken while the arithmetic unit is busy");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !sts.busy)
        else $error("arithmetic unit restarted mid-operation");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result beat raised outside the finish step");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual-tier latency estimator. Sample beats are
// built as running counter walks: mostly steady traffic, with noise, idle
// paths, stopped clockticks, floods, repeats and wraps mixed in. Each
// accepted sample is run through a local predictor of the smoothing and
// Little's-law arithmetic. Result beats are compared field by field in order.
// Registers are rewritten between phases while the block is drained, over
// extreme and random settings. Both channels stall at random in bursts.
// ----------------------------------------------------------------------------
module tb;
    import dtle_pkg::*;

    localparam int SettleCycles = 600;
    localparam int CycleLimit   = 8_000_000;
    localparam int PhaseItems   = 170;
    localparam int Phases       = 9;

    localparam logic [IdxW-1:0] RegFirstSpare = 8'd4;
    localparam logic [IdxW-1:0] RegLastSpare  = 8'hFF;

    typedef enum {
        GEN_STEADY,
        GEN_NOISE,
        GEN_IDLE_PATH,
        GEN_NO_CLOCK,
        GEN_FLOOD,
        GEN_REPEAT
    } gen_kind_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic    s_valid = 1'b0;
    sample_t s_data  = '0;
    logic    r_ready = 1'b0;
    logic    c_valid = 1'b0;
    cfg_t    c_data  = '0;

    dtle_stream_if #(.T(sample_t)) sample_ch ();
    dtle_stream_if #(.T(result_t)) result_ch ();
    dtle_stream_if #(.T(cfg_t))    cfg_ch ();

    assign sample_ch.valid = s_valid;
    assign sample_ch.data  = s_data;
    assign result_ch.ready = r_ready;
    assign cfg_ch.valid    = c_valid;
    assign cfg_ch.data     = c_data;

    dual_tier_latency_estimator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    sample_t pending_samples[$];
    cfg_t    pending_writes[$];
    result_t expected_estimates[$];

    int unsigned cycles     = 0;
    int unsigned mismatches = 0;
    bit          idle_on    = 1'b1;
    int unsigned s_gap      = 0;
    int unsigned r_stall    = 0;
    sample_t     reading    = '0;

    logic [ShiftW-1:0] smooth_shift = ShiftReset;
    logic [RegW-1:0]   local_floor  = LocalMinReset;
    logic [RegW-1:0]   remote_floor = RemoteMinReset;
    logic [RegW-1:0]   tsc_mhz      = ClockMhzReset;

    sample_t     last_reading = '0;
    logic [63:0] avg_local_occ  = '0;
    logic [63:0] avg_local_ins  = '0;
    logic [63:0] avg_remote_occ = '0;
    logic [63:0] avg_remote_ins = '0;
    bit          primed         = 1'b0;

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic logic [63:0] smooth(logic [63:0] avg, logic [63:0] delta,
                                           logic [ShiftW-1:0] sh);
        logic [71:0] acc;
        if (sh == 0)
            return delta;
        acc = ({8'd0, avg} << sh) - {8'd0, avg} + {8'd0, delta};
        return 64'(acc >> sh);
    endfunction

    function automatic logic [63:0] little_latency(logic [63:0] occ, logic [63:0] ins,
                                                   logic [63:0] dtsc, logic [63:0] dclk,
                                                   logic [RegW-1:0] floor_ns,
                                                   logic [RegW-1:0] mhz);
        logic [63:0]  quo;
        logic [79:0]  ns_wide;
        logic [63:0]  ns;
        logic [127:0] prod;
        logic [63:0]  prod_sat;
        logic [63:0]  lat;
        if (ins == 0 || dclk == 0)
            return {48'd0, floor_ns};
        quo     = occ / ins;
        ns_wide = ({16'd0, dtsc} * 80'd1000) / {64'd0, (mhz == 0) ? 16'd1 : mhz};
        ns      = (ns_wide[79:64] != 0) ? '1 : ns_wide[63:0];
        prod    = {64'd0, quo} * {64'd0, ns};
        prod_sat = (prod[127:64] != 0) ? '1 : prod[63:0];
        lat     = prod_sat / dclk;
        return (lat > {48'd0, floor_ns}) ? lat : {48'd0, floor_ns};
    endfunction

    function automatic bit estimate_latencies(sample_t s, output result_t r);
        sample_t d;
        d.local_occupancy_count  = s.local_occupancy_count - last_reading.local_occupancy_count;
        d.local_insert_count     = s.local_insert_count - last_reading.local_insert_count;
        d.local_clocktick_count  = s.local_clocktick_count - last_reading.local_clocktick_count;
        d.local_timestamp        = s.local_timestamp - last_reading.local_timestamp;
        d.remote_occupancy_count = s.remote_occupancy_count
                                   - last_reading.remote_occupancy_count;
        d.remote_insert_count    = s.remote_insert_count - last_reading.remote_insert_count;
        d.remote_clocktick_count = s.remote_clocktick_count
                                   - last_reading.remote_clocktick_count;
        d.remote_timestamp       = s.remote_timestamp - last_reading.remote_timestamp;
        last_reading = s;
        r = '0;
        if (!primed)
        begin
            primed = 1'b1;
            return 1'b0;
        end
        avg_local_occ  = smooth(avg_local_occ, d.local_occupancy_count, smooth_shift);
        avg_local_ins  = smooth(avg_local_ins, d.local_insert_count, smooth_shift);
        avg_remote_occ = smooth(avg_remote_occ, d.remote_occupancy_count, smooth_shift);
        avg_remote_ins = smooth(avg_remote_ins, d.remote_insert_count, smooth_shift);
        r.local_latency  = little_latency(avg_local_occ, avg_local_ins, d.local_timestamp,
                                          d.local_clocktick_count, local_floor, tsc_mhz);
        r.remote_latency = little_latency(avg_remote_occ, avg_remote_ins,
                                          d.remote_timestamp, d.remote_clocktick_count,
                                          remote_floor, tsc_mhz);
        r.local_slower           = r.local_latency > r.remote_latency;
        r.local_interval_ticks   = d.local_timestamp;
        r.remote_interval_ticks  = d.remote_timestamp;
        r.local_clocktick_delta  = d.local_clocktick_count;
        r.remote_clocktick_delta = d.remote_clocktick_count;
        return 1'b1;
    endfunction

    task automatic advance_path(gen_kind_t kind, inout logic [63:0] occ,
                                inout logic [63:0] ins, inout logic [63:0] clk_cnt,
                                inout logic [63:0] ts);
        int unsigned ins_step;
        int unsigned ts_step;
        ins_step = $urandom_range(1, 4000);
        ts_step  = $urandom_range(100, 2_000_000);
        case (kind)
            GEN_STEADY, GEN_NO_CLOCK:
            begin
                occ += 64'(ins_step) * 64'($urandom_range(0, 1200))
                       + 64'($urandom_range(0, ins_step));
                ins += 64'(ins_step);
                ts  += 64'(ts_step);
                if (kind == GEN_STEADY)
                    clk_cnt += 64'(ts_step / $urandom_range(1, 8));
            end
            GEN_IDLE_PATH:
            begin
                occ     += 64'($urandom_range(0, 500));
                ts      += 64'(ts_step);
                clk_cnt += 64'(ts_step / $urandom_range(1, 8));
            end
            GEN_FLOOD:
            begin
                occ     += {$urandom, $urandom};
                ins     += 64'($urandom_range(1, 3));
                ts      += {$urandom, $urandom};
                clk_cnt += 64'($urandom_range(1, 16));
            end
            GEN_NOISE:
            begin
                occ     = {$urandom, $urandom};
                ins     = {$urandom, $urandom};
                clk_cnt = {$urandom, $urandom};
                ts      = {$urandom, $urandom};
            end
            default: ;
        endcase
    endtask

    task automatic push_sample(gen_kind_t local_kind, gen_kind_t remote_kind);
        advance_path(local_kind, reading.local_occupancy_count, reading.local_insert_count,
                     reading.local_clocktick_count, reading.local_timestamp);
        advance_path(remote_kind, reading.remote_occupancy_count,
                     reading.remote_insert_count, reading.remote_clocktick_count,
                     reading.remote_timestamp);
        pending_samples.push_back(reading);
    endtask

    function automatic gen_kind_t pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return GEN_STEADY;
        if (roll < 86)
            return GEN_NOISE;
        if (roll < 90)
            return GEN_IDLE_PATH;
        if (roll < 94)
            return GEN_NO_CLOCK;
        if (roll < 97)
            return GEN_FLOOD;
        return GEN_REPEAT;
    endfunction

    task automatic write_reg(logic [IdxW-1:0] index, logic [RegW-1:0] value);
        cfg_t w;
        w.index = index;
        w.value = value;
        pending_writes.push_back(w);
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || s_valid || expected_estimates.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid <= 1'b0;
            s_gap   <= 0;
        end
        else if (s_valid && !sample_ch.ready)
        begin
            // hold
        end
        else if (s_valid && idle_on && $urandom_range(0, 5) == 0)
        begin
            s_valid <= 1'b0;
            s_gap   <= $urandom_range(0, 17);
        end
        else if (s_gap != 0)
        begin
            s_valid <= 1'b0;
            s_gap   <= s_gap - 1;
        end
        else if (pending_samples.size() != 0)
        begin
            s_data  <= pending_samples.pop_front();
            s_valid <= 1'b1;
        end
        else
        begin
            s_valid <= 1'b0;
        end
    end

    // register write driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid <= 1'b0;
        end
        else if (c_valid && !cfg_ch.ready)
        begin
            // hold
        end
        else if (pending_writes.size() != 0)
        begin
            c_data  <= pending_writes.pop_front();
            c_valid <= 1'b1;
        end
        else
        begin
            c_valid <= 1'b0;
        end
    end

    // result backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_ready <= 1'b0;
            r_stall <= 0;
        end
        else if (r_stall != 0)
        begin
            r_ready <= 1'b0;
            r_stall <= r_stall - 1;
        end
        else if (idle_on && $urandom_range(0, 15) == 0)
        begin
            r_ready <= 1'b0;
            r_stall <= $urandom_range(0, 17);
        end
        else
        begin
            r_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && c_valid && cfg_ch.ready)
        begin
            case (c_data.index)
                RegSmoothingShift:   smooth_shift = c_data.value[ShiftW-1:0];
                RegLocalMinLatency:  local_floor  = c_data.value;
                RegRemoteMinLatency: remote_floor = c_data.value;
                RegClockMhz:         tsc_mhz      = c_data.value;
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && s_valid && sample_ch.ready)
        begin
            if (estimate_latencies(s_data, r))
                expected_estimates.push_back(r);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && result_ch.valid && r_ready)
        begin
            got = result_ch.data;
            if (expected_estimates.size() == 0)
            begin
                report("result beat with no estimate pending");
            end
            else
            begin
                want = expected_estimates.pop_front();
                check_field("local_latency", got.local_latency, want.local_latency);
                check_field("remote_latency", got.remote_latency, want.remote_latency);
                check_field("local_slower", 64'(got.local_slower), 64'(want.local_slower));
                check_field("local_interval_ticks", got.local_interval_ticks,
                            want.local_interval_ticks);
                check_field("remote_interval_ticks", got.remote_interval_ticks,
                            want.remote_interval_ticks);
                check_field("local_clocktick_delta", got.local_clocktick_delta,
                            want.local_clocktick_delta);
                check_field("remote_clocktick_delta", got.remote_clocktick_delta,
                            want.remote_clocktick_delta);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [RegW-1:0] shift_v;
        logic [RegW-1:0] lmin_v;
        logic [RegW-1:0] rmin_v;
        logic [RegW-1:0] mhz_v;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // prime, repeat, extremes, wrap, zero inserts and clockticks, floods
        push_sample(GEN_NOISE, GEN_NOISE);
        push_sample(GEN_REPEAT, GEN_REPEAT);
        reading = '1;
        push_sample(GEN_REPEAT, GEN_REPEAT);
        reading = '0;
        push_sample(GEN_REPEAT, GEN_REPEAT);
        push_sample(GEN_STEADY, GEN_STEADY);
        push_sample(GEN_STEADY, GEN_STEADY);
        push_sample(GEN_NO_CLOCK, GEN_STEADY);
        push_sample(GEN_STEADY, GEN_IDLE_PATH);
        push_sample(GEN_FLOOD, GEN_FLOOD);
        push_sample(GEN_STEADY, GEN_STEADY);
        reading = {8{64'hFFFF_FFFF_FFFF_F000}};
        push_sample(GEN_STEADY, GEN_STEADY);
        push_sample(GEN_STEADY, GEN_STEADY);
        push_sample(GEN_NOISE, GEN_STEADY);
        push_sample(GEN_IDLE_PATH, GEN_NO_CLOCK);
        repeat (6) push_sample(GEN_STEADY, GEN_STEADY);

        for (int p = 1; p <= Phases; p++)
        begin
            drain();
            idle_on = (p % 3 != 2) && (p != Phases);
            case (p)
                1:
                begin
                    shift_v = 16'd0;
                    lmin_v  = 16'd0;
                    rmin_v  = 16'd0;
                    mhz_v   = 16'd1;
                end
                2:
                begin
                    shift_v = 16'd7;
                    lmin_v  = 16'hFFFF;
                    rmin_v  = 16'hFFFF;
                    mhz_v   = 16'hFFFF;
                end
                3:
                begin
                    shift_v = 16'hFFF8 | 16'($urandom_range(0, 7));
                    lmin_v  = 16'($urandom_range(0, 2000));
                    rmin_v  = 16'($urandom_range(0, 2000));
                    mhz_v   = 16'd0;
                    write_reg(RegLastSpare, 16'hFFFF);
                    write_reg(IdxW'($urandom_range(RegFirstSpare, RegLastSpare)),
                              16'($urandom));
                end
                Phases:
                begin
                    shift_v = {13'd0, ShiftReset};
                    lmin_v  = LocalMinReset;
                    rmin_v  = RemoteMinReset;
                    mhz_v   = ClockMhzReset;
                end
                default:
                begin
                    shift_v = 16'($urandom);
                    lmin_v  = 16'($urandom_range(0, 2000));
                    rmin_v  = 16'($urandom_range(0, 2000));
                    mhz_v   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                          : 16'($urandom_range(1000, 4000));
                end
            endcase
            write_reg(RegSmoothingShift, shift_v);
            write_reg(RegLocalMinLatency, lmin_v);
            write_reg(RegRemoteMinLatency, rmin_v);
            write_reg(RegClockMhz, mhz_v);
            while (pending_writes.size() != 0 || c_valid)
                @(negedge clk);
            repeat (PhaseItems) push_sample(pick_kind(), pick_kind());
        end

        drain();
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

>>> dual_tier_latency_estimator.f
hw/rtl/dtle_pkg.sv
hw/rtl/dtle_stream_if.sv
hw/rtl/dtle_arith.sv
hw/rtl/dual_tier_latency_estimator.sv
dv/tb.sv
